// ----- hdl/mpsas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsas_pkg
// Types and constants shared by the settle-and-average sequencer modules.
// ----------------------------------------------------------------------------
package mpsas_pkg;

	// field widths
	localparam int TICK_W      = 16;
	localparam int SPEED_W     = 19;
	localparam int TORQUE_W    = 16;
	localparam int INDEX_W     = 8;
	localparam int SETTLE_W    = 32;
	localparam int HOLD_W      = 47;
	localparam int STEP_W      = 35;
	localparam int ELAPSED_W   = 32;
	localparam int ANGLE_W     = 48;
	localparam int TRQ_TOT_W   = 48;
	localparam int SPD_TOT_W   = 52;
	localparam int TALLY_W     = 32;
	localparam int DIV_W       = 52;
	localparam int DIV_CNT_W   = 6;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 47;

	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TIME = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_ANGLE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_POINT_TOTAL = 2'd2;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 32'd400000;
	localparam logic [HOLD_W-1:0]   HOLD_RESET   = 47'd36000000000;
	localparam logic [INDEX_W-1:0]  TOTAL_RESET  = 8'd8;

	// mean limits
	localparam logic [DIV_W-1:0] SPEED_POS_LIM  = 52'd262143;
	localparam logic [DIV_W-1:0] SPEED_NEG_LIM  = 52'd262144;
	localparam logic [DIV_W-1:0] TORQUE_POS_LIM = 52'd32767;
	localparam logic [DIV_W-1:0] TORQUE_NEG_LIM = 52'd32768;

	typedef struct packed {
		logic [SETTLE_W-1:0] settle_time_us;
		logic [HOLD_W-1:0]   hold_angle;
		logic [INDEX_W-1:0]  point_total;
	} cfg_regs_t;

	// one classified tick waiting for the back end
	typedef struct packed {
		logic [TICK_W-1:0]          tick_us;
		logic signed [SPEED_W-1:0]  speed;
		logic signed [TORQUE_W-1:0] load_torque;
		logic [STEP_W-1:0]          angle_step;
	} queued_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TIME,
		ST_ACCUM,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// ----- hdl/mpsas_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsas interfaces
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mpsas_tick_if;
	logic                                 valid;
	logic                                 ready;
	logic [mpsas_pkg::TICK_W-1:0]         tick_us;
	logic signed [mpsas_pkg::SPEED_W-1:0] speed;
	logic signed [mpsas_pkg::TORQUE_W-1:0] load_torque;

	modport source (output valid, output tick_us, output speed, output load_torque,
		input ready);
	modport sink (input valid, input tick_us, input speed, input load_torque,
		output ready);
endinterface

interface mpsas_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  point_complete;
	logic                                  all_done;
	logic signed [mpsas_pkg::SPEED_W-1:0]  mean_speed;
	logic signed [mpsas_pkg::TORQUE_W-1:0] mean_torque;
	logic [mpsas_pkg::INDEX_W-1:0]         point_index;

	modport source (output valid, output point_complete, output all_done,
		output mean_speed, output mean_torque, output point_index, input ready);
	modport sink (input valid, input point_complete, input all_done,
		input mean_speed, input mean_torque, input point_index, output ready);
endinterface

interface mpsas_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [mpsas_pkg::CFG_INDEX_W-1:0]   index;
	logic [mpsas_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/mpsas_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsas_front
// Accepts ticks, forms |speed| * tick_us and hands the item to the queue.
// ----------------------------------------------------------------------------
module mpsas_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	mpsas_tick_if.sink                   tick,
	input  wire logic                    queue_full,
	output logic                         push,
	output mpsas_pkg::queued_item_t      push_item
);

	logic                           v_s1;
	mpsas_pkg::queued_item_t        item_s1;
	logic [mpsas_pkg::SPEED_W-1:0]  speed_mag;

	assign push       = v_s1 && !queue_full;
	assign push_item  = item_s1;
	assign tick.ready = !v_s1 || !queue_full;

	// most negative speed still reads right as an unsigned magnitude
	assign speed_mag = tick.speed[mpsas_pkg::SPEED_W-1] ? -tick.speed : tick.speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1.tick_us     <= tick.tick_us;
			item_s1.speed       <= tick.speed;
			item_s1.load_torque <= tick.load_torque;
			item_s1.angle_step  <= mpsas_pkg::STEP_W'(speed_mag * tick.tick_us);
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mpsas_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsas_fifo
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module mpsas_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire mpsas_pkg::queued_item_t push_item,
	output logic                         full,
	input  wire logic                    pop,
	output logic                         head_valid,
	output mpsas_pkg::queued_item_t      head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mpsas_pkg::queued_item_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mpsas_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsas_div
// Restoring divider, one quotient bit per cycle, two numerators sharing
// one divisor.
// ----------------------------------------------------------------------------
module mpsas_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mpsas_pkg::DIV_W-1:0]   num_a,
	input  wire logic [mpsas_pkg::DIV_W-1:0]   num_b,
	input  wire logic [mpsas_pkg::TALLY_W-1:0] den,
	output logic                               done,
	output logic [mpsas_pkg::DIV_W-1:0]        quo_a,
	output logic [mpsas_pkg::DIV_W-1:0]        quo_b
);

	localparam int DW = mpsas_pkg::DIV_W;
	localparam int RW = mpsas_pkg::TALLY_W;

	logic                               busy_q;
	logic                               done_q;
	logic [mpsas_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [DW-1:0]                      a_q;
	logic [DW-1:0]                      b_q;
	logic [RW-1:0]                      rem_a_q;
	logic [RW-1:0]                      rem_b_q;
	logic [RW-1:0]                      den_q;
	logic [RW:0]                        sh_a;
	logic [RW:0]                        sh_b;
	logic                               fit_a;
	logic                               fit_b;
	logic [RW:0]                        dif_a;
	logic [RW:0]                        dif_b;

	assign done  = done_q;
	assign quo_a = a_q;
	assign quo_b = b_q;

	assign sh_a  = {rem_a_q, a_q[DW-1]};
	assign sh_b  = {rem_b_q, b_q[DW-1]};
	assign fit_a = (sh_a >= {1'b0, den_q});
	assign fit_b = (sh_b >= {1'b0, den_q});
	assign dif_a = sh_a - {1'b0, den_q};
	assign dif_b = sh_b - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == mpsas_pkg::DIV_CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q     <= num_a;
			b_q     <= num_b;
			den_q   <= den;
			rem_a_q <= '0;
			rem_b_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the narrow register
			rem_a_q <= fit_a ? dif_a[RW-1:0] : sh_a[RW-1:0];
			rem_b_q <= fit_b ? dif_b[RW-1:0] : sh_b[RW-1:0];
			a_q     <= {a_q[DW-2:0], fit_a};
			b_q     <= {b_q[DW-2:0], fit_b};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mpsas_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpsas_back
// Per-point accumulators, settle and hold tests, mean division and the
// result register.
// ----------------------------------------------------------------------------
module mpsas_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mpsas_pkg::cfg_regs_t    cfg_regs,
	input  wire logic                    head_valid,
	input  wire mpsas_pkg::queued_item_t head_item,
	output logic                         pop,
	mpsas_result_if.source               result
);

	localparam int SW = mpsas_pkg::SPEED_W;
	localparam int TW = mpsas_pkg::TORQUE_W;
	localparam int PW = mpsas_pkg::SPD_TOT_W;
	localparam int QW = mpsas_pkg::TRQ_TOT_W;
	localparam int AW = mpsas_pkg::ANGLE_W;
	localparam int EW = mpsas_pkg::ELAPSED_W;
	localparam int DW = mpsas_pkg::DIV_W;

	mpsas_pkg::back_state_t state_q, state_d;

	mpsas_pkg::queued_item_t         item_q;
	logic [EW-1:0]                   elapsed_q;
	logic [AW-1:0]                   swept_q;
	logic signed [QW-1:0]            torque_total_q;
	logic signed [PW-1:0]            speed_total_q;
	logic [mpsas_pkg::TALLY_W-1:0]   tally_q;
	logic [mpsas_pkg::INDEX_W-1:0]   point_q;
	logic                            sample_q;
	logic                            ready_q;
	logic                            div_used_q;
	logic                            spd_neg_q;
	logic                            trq_neg_q;

	logic                            out_valid_q;
	logic                            out_ready_q;
	logic                            out_done_q;
	logic signed [SW-1:0]            out_speed_q;
	logic signed [TW-1:0]            out_torque_q;
	logic [mpsas_pkg::INDEX_W-1:0]   out_index_q;

	logic                            active;
	logic                            hold_hit;
	logic                            tally_zero;
	logic                            div_start;
	logic                            div_done;
	logic                            out_load;
	logic [EW:0]                     elapsed_sum;
	logic [EW-1:0]                   elapsed_next;
	logic [AW:0]                     swept_sum;
	logic signed [PW:0]              speed_sum;
	logic signed [QW:0]              trq_sum_ext;
	logic [DW-1:0]                   spd_mag;
	logic [QW-1:0]                   trq_mag;
	logic [DW-1:0]                   quo_spd;
	logic [DW-1:0]                   quo_trq;
	logic signed [SW-1:0]            mean_spd;
	logic signed [TW-1:0]            mean_trq;

	assign active     = (point_q < cfg_regs.point_total);
	assign hold_hit   = (swept_q >= {1'b0, cfg_regs.hold_angle});
	assign tally_zero = (tally_q == '0);

	assign elapsed_sum  = {1'b0, elapsed_q} + (EW + 1)'(item_q.tick_us);
	assign elapsed_next = elapsed_sum[EW] ? '1 : elapsed_sum[EW-1:0];
	assign swept_sum    = {1'b0, swept_q} + (AW + 1)'(item_q.angle_step);
	assign speed_sum    = {speed_total_q[PW-1], speed_total_q}
		+ {{(PW + 1 - SW){item_q.speed[SW-1]}}, item_q.speed};
	assign trq_sum_ext  = {torque_total_q[QW-1], torque_total_q}
		+ {{(QW + 1 - TW){item_q.load_torque[TW-1]}}, item_q.load_torque};

	assign spd_mag = speed_total_q[PW-1] ? DW'(-speed_total_q) : DW'(speed_total_q);
	assign trq_mag = torque_total_q[QW-1] ? QW'(-torque_total_q) : QW'(torque_total_q);

	mpsas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_a  (spd_mag),
		.num_b  (DW'(trq_mag)),
		.den    (tally_q),
		.done   (div_done),
		.quo_a  (quo_spd),
		.quo_b  (quo_trq)
	);

	// clamp the magnitude quotient and put the sign back; zero when no division was used
	always_comb begin
		if (!(ready_q && div_used_q)) begin
			mean_spd = '0;
		end else if (spd_neg_q) begin
			mean_spd = (quo_spd > mpsas_pkg::SPEED_NEG_LIM) ? {1'b1, {(SW - 1){1'b0}}}
				: -SW'(quo_spd);
		end else begin
			mean_spd = (quo_spd > mpsas_pkg::SPEED_POS_LIM) ? {1'b0, {(SW - 1){1'b1}}}
				: SW'(quo_spd);
		end

		if (!(ready_q && div_used_q)) begin
			mean_trq = '0;
		end else if (trq_neg_q) begin
			mean_trq = (quo_trq > mpsas_pkg::TORQUE_NEG_LIM) ? {1'b1, {(TW - 1){1'b0}}}
				: -TW'(quo_trq);
		end else begin
			mean_trq = (quo_trq > mpsas_pkg::TORQUE_POS_LIM) ? {1'b0, {(TW - 1){1'b1}}}
				: TW'(quo_trq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpsas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			mpsas_pkg::ST_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = mpsas_pkg::ST_TIME;
				end
			end
			mpsas_pkg::ST_TIME: begin
				state_d = active ? mpsas_pkg::ST_ACCUM : mpsas_pkg::ST_EMIT;
			end
			mpsas_pkg::ST_ACCUM: begin
				state_d = mpsas_pkg::ST_CHECK;
			end
			mpsas_pkg::ST_CHECK: begin
				if (hold_hit && !tally_zero) begin
					div_start = 1'b1;
					state_d   = mpsas_pkg::ST_DIV;
				end else begin
					state_d = mpsas_pkg::ST_EMIT;
				end
			end
			mpsas_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = mpsas_pkg::ST_EMIT;
				end
			end
			mpsas_pkg::ST_EMIT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = mpsas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mpsas_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q      <= '0;
			swept_q        <= '0;
			torque_total_q <= '0;
			speed_total_q  <= '0;
			tally_q        <= '0;
			point_q        <= '0;
			sample_q       <= 1'b0;
			ready_q        <= 1'b0;
			div_used_q     <= 1'b0;
			spd_neg_q      <= 1'b0;
			trq_neg_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				mpsas_pkg::ST_TIME: begin
					ready_q    <= 1'b0;
					div_used_q <= 1'b0;
					if (active) begin
						elapsed_q <= elapsed_next;
						sample_q  <= (elapsed_next > cfg_regs.settle_time_us);
					end
				end
				mpsas_pkg::ST_ACCUM: begin
					if (sample_q) begin
						swept_q <= swept_sum[AW] ? '1 : swept_sum[AW-1:0];
						if (speed_sum[PW] != speed_sum[PW-1]) begin
							speed_total_q <= speed_sum[PW] ? {1'b1, {(PW - 1){1'b0}}}
								: {1'b0, {(PW - 1){1'b1}}};
						end else begin
							speed_total_q <= speed_sum[PW-1:0];
						end
						if (trq_sum_ext[QW] != trq_sum_ext[QW-1]) begin
							torque_total_q <= trq_sum_ext[QW] ? {1'b1, {(QW - 1){1'b0}}}
								: {1'b0, {(QW - 1){1'b1}}};
						end else begin
							torque_total_q <= trq_sum_ext[QW-1:0];
						end
						if (tally_q != '1) begin
							tally_q <= tally_q + 1'b1;
						end
					end
				end
				mpsas_pkg::ST_CHECK: begin
					if (hold_hit) begin
						// point complete: the divider latches its operands at this edge when there are samples
						ready_q        <= 1'b1;
						div_used_q     <= !tally_zero;
						spd_neg_q      <= speed_total_q[PW-1];
						trq_neg_q      <= torque_total_q[QW-1];
						elapsed_q      <= '0;
						swept_q        <= '0;
						torque_total_q <= '0;
						speed_total_q  <= '0;
						tally_q        <= '0;
						point_q        <= point_q + 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mpsas_pkg::ST_IDLE && head_valid) begin
			item_q <= head_item;
		end
		if (out_load) begin
			out_ready_q  <= ready_q;
			out_done_q   <= !active;
			out_speed_q  <= mean_spd;
			out_torque_q <= mean_trq;
			out_index_q  <= point_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.point_complete = out_ready_q;
	assign result.all_done       = out_done_q;
	assign result.mean_speed     = out_speed_q;
	assign result.mean_torque    = out_torque_q;
	assign result.point_index    = out_index_q;

endmodule
`default_nettype wire

// ----- hdl/multi_point_settle_average_sequencer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_point_settle_average_sequencer_core
// Settle, sample and average sequencer over a list of test points.
//
//   channel  dir  handshake      payload
//   tick     in   valid/ready    tick_us, speed, load_torque
//   result   out  valid/ready    point_complete, all_done, mean_speed,
//                                mean_torque, point_index
//   cfg      in   valid/ready    index, data (always ready)
//
// A tick passes the back-end states idle, time, accumulate, check and emit,
// skips accumulate and check once the sequence is finished, and waits on the
// 52-step serial divider before emit when it completes a point with samples.
// The front stage and the queue keep taking ticks while the back end works, until the queue is full.
// arst_n clears all accumulators, the point counter and loads register
// defaults. A stalled result holds the back end in its output step.
// ----------------------------------------------------------------------------
module multi_point_settle_average_sequencer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mpsas_tick_if.sink     tick,
	mpsas_result_if.source result,
	mpsas_cfg_if.sink      cfg
);

	mpsas_pkg::cfg_regs_t        cfg_q;
	mpsas_pkg::queued_item_t     push_item;
	mpsas_pkg::queued_item_t     head_item;
	logic                        push;
	logic                        queue_full;
	logic                        pop;
	logic                        head_valid;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_time_us <= mpsas_pkg::SETTLE_RESET;
			cfg_q.hold_angle     <= mpsas_pkg::HOLD_RESET;
			cfg_q.point_total    <= mpsas_pkg::TOTAL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				mpsas_pkg::REG_SETTLE_TIME: begin
					cfg_q.settle_time_us <= cfg.data[mpsas_pkg::SETTLE_W-1:0];
				end
				mpsas_pkg::REG_HOLD_ANGLE: begin
					cfg_q.hold_angle <= cfg.data[mpsas_pkg::HOLD_W-1:0];
				end
				mpsas_pkg::REG_POINT_TOTAL: begin
					cfg_q.point_total <= cfg.data[mpsas_pkg::INDEX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	mpsas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	mpsas_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	mpsas_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire

// ----- dv/tb_multi_point_settle_average_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// tb_multi_point_settle_average_sequencer_core
// Self-checking bench for the settle-and-average sequencer. Ticks go in from
// a backlog queue and results are checked in order against a cycle-free
// model of the point sequence. Register settings change between phases.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_multi_point_settle_average_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICK_W      = mpsas_pkg::TICK_W;
	localparam int SPEED_W     = mpsas_pkg::SPEED_W;
	localparam int TORQUE_W    = mpsas_pkg::TORQUE_W;
	localparam int INDEX_W     = mpsas_pkg::INDEX_W;
	localparam int SETTLE_W    = mpsas_pkg::SETTLE_W;
	localparam int HOLD_W      = mpsas_pkg::HOLD_W;
	localparam int ELAPSED_W   = mpsas_pkg::ELAPSED_W;
	localparam int ANGLE_W     = mpsas_pkg::ANGLE_W;
	localparam int TRQ_TOT_W   = mpsas_pkg::TRQ_TOT_W;
	localparam int SPD_TOT_W   = mpsas_pkg::SPD_TOT_W;
	localparam int TALLY_W     = mpsas_pkg::TALLY_W;
	localparam int CFG_INDEX_W = mpsas_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = mpsas_pkg::CFG_DATA_W;

	localparam int STALL_LIMIT = 5000;
	localparam int PRINT_LIMIT = 50;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	localparam longint TORQUE_TOTAL_MAX = (longint'(1) <<< (TRQ_TOT_W - 1)) - 1;
	localparam longint SPEED_SUM_MAX    = (longint'(1) <<< (SPD_TOT_W - 1)) - 1;
	localparam longint MEAN_SPEED_MAX   = (longint'(1) <<< (SPEED_W - 1)) - 1;
	localparam longint MEAN_TORQUE_MAX  = (longint'(1) <<< (TORQUE_W - 1)) - 1;

	localparam logic signed [SPEED_W-1:0]  SPEED_LOW   = {1'b1, {(SPEED_W-1){1'b0}}};
	localparam logic signed [SPEED_W-1:0]  SPEED_HIGH  = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic signed [TORQUE_W-1:0] TORQUE_LOW  = {1'b1, {(TORQUE_W-1){1'b0}}};
	localparam logic signed [TORQUE_W-1:0] TORQUE_HIGH = {1'b0, {(TORQUE_W-1){1'b1}}};

	typedef struct packed {
		logic [TICK_W-1:0]          tick_us;
		logic signed [SPEED_W-1:0]  speed;
		logic signed [TORQUE_W-1:0] load_torque;
	} tick_item_t;

	typedef struct packed {
		logic                       point_complete;
		logic                       all_done;
		logic signed [SPEED_W-1:0]  mean_speed;
		logic signed [TORQUE_W-1:0] mean_torque;
		logic [INDEX_W-1:0]         point_index;
	} point_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mpsas_tick_if   tick_bus ();
	mpsas_result_if result_bus ();
	mpsas_cfg_if    cfg_bus ();

	multi_point_settle_average_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model copy of the registers and the per-point accumulators
	mpsas_pkg::cfg_regs_t shadow_cfg = '{mpsas_pkg::SETTLE_RESET, mpsas_pkg::HOLD_RESET,
		mpsas_pkg::TOTAL_RESET};
	logic [ELAPSED_W-1:0] point_elapsed_us = '0;
	logic [ANGLE_W-1:0]   point_swept_angle = '0;
	longint               point_torque_total = 0;
	longint               point_speed_sum = 0;
	logic [TALLY_W-1:0]   point_samples = '0;
	logic [INDEX_W-1:0]   point_number_now = '0;

	tick_item_t    tick_backlog[$];
	point_result_t pending_point_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int failure_count = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	function automatic longint clamp_sum(input longint v, input longint hi);
		return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
	endfunction

	function automatic longint mean_of_point(input longint total,
			input logic [TALLY_W-1:0] count, input longint hi);
		longint q;
		if (count == '0) begin
			return 0;
		end
		q = total / longint'({32'd0, count});
		return clamp_sum(q, hi);
	endfunction

	function automatic point_result_t settle_average_tick(input tick_item_t it);
		logic [63:0]   elapsed_next;
		logic [63:0]   swept_next;
		longint        speed_val;
		longint        torque_val;
		longint        speed_mag;
		longint        speed_mean;
		longint        torque_mean;
		point_result_t res;
		res = '0;
		speed_val = longint'($signed(it.speed));
		torque_val = longint'($signed(it.load_torque));
		if (point_number_now < shadow_cfg.point_total) begin
			elapsed_next = 64'(point_elapsed_us) + 64'(it.tick_us);
			point_elapsed_us = (|elapsed_next[63:ELAPSED_W]) ? '1
				: elapsed_next[ELAPSED_W-1:0];
			// sampling starts only once elapsed time is strictly past settle
			if (point_elapsed_us > shadow_cfg.settle_time_us) begin
				speed_mag = (speed_val < 0) ? -speed_val : speed_val;
				swept_next = 64'(point_swept_angle) + 64'(speed_mag) * 64'(it.tick_us);
				point_swept_angle = (|swept_next[63:ANGLE_W]) ? '1
					: swept_next[ANGLE_W-1:0];
				point_torque_total = clamp_sum(point_torque_total + torque_val,
					TORQUE_TOTAL_MAX);
				point_speed_sum = clamp_sum(point_speed_sum + speed_val, SPEED_SUM_MAX);
				if (point_samples != '1) begin
					point_samples = point_samples + 1'b1;
				end
			end
			if (point_swept_angle >= shadow_cfg.hold_angle) begin
				speed_mean = mean_of_point(point_speed_sum, point_samples, MEAN_SPEED_MAX);
				torque_mean = mean_of_point(point_torque_total, point_samples,
					MEAN_TORQUE_MAX);
				res.point_complete = 1'b1;
				res.mean_speed = speed_mean[SPEED_W-1:0];
				res.mean_torque = torque_mean[TORQUE_W-1:0];
				point_elapsed_us = '0;
				point_swept_angle = '0;
				point_torque_total = 0;
				point_speed_sum = 0;
				point_samples = '0;
				point_number_now = point_number_now + 1'b1;
			end
		end
		res.all_done = (point_number_now >= shadow_cfg.point_total);
		res.point_index = point_number_now;
		return res;
	endfunction

	task automatic note_failure(input string what);
		failure_count++;
		if (failure_count <= PRINT_LIMIT) begin
			$display("[%0t] error: %s", $realtime, what);
		end
	endtask

	function automatic void queue_tick(input logic [TICK_W-1:0] t,
			input logic signed [SPEED_W-1:0] s, input logic signed [TORQUE_W-1:0] q);
		tick_item_t it;
		it.tick_us = t;
		it.speed = s;
		it.load_torque = q;
		tick_backlog.push_back(it);
	endfunction

	function automatic tick_item_t random_tick();
		tick_item_t it;
		case ($urandom_range(9))
			0: it.tick_us = '0;
			1: it.tick_us = '1;
			2, 3: it.tick_us = TICK_W'($urandom());
			default: it.tick_us = TICK_W'($urandom_range(2000));
		endcase
		case ($urandom_range(9))
			0: it.speed = SPEED_LOW;
			1: it.speed = SPEED_HIGH;
			2: it.speed = '0;
			3, 4, 5, 6: it.speed = SPEED_W'($urandom());
			default: it.speed = SPEED_W'(int'($urandom_range(4000)) - 2000);
		endcase
		case ($urandom_range(9))
			0: it.load_torque = TORQUE_LOW;
			1: it.load_torque = TORQUE_HIGH;
			2: it.load_torque = '0;
			default: it.load_torque = TORQUE_W'($urandom());
		endcase
		return it;
	endfunction

	function automatic void set_traffic(input int mode);
		case (mode)
			1: begin
				send_idle_pct = 47;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 47;
			end
			3: begin
				send_idle_pct = 37;
				recv_stall_pct = 37;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endfunction

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			mpsas_pkg::REG_SETTLE_TIME: shadow_cfg.settle_time_us = value[SETTLE_W-1:0];
			mpsas_pkg::REG_HOLD_ANGLE:  shadow_cfg.hold_angle = value[HOLD_W-1:0];
			mpsas_pkg::REG_POINT_TOTAL: shadow_cfg.point_total = value[INDEX_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits are junk on purpose, the block keeps only the field width
	task automatic apply_settings(input logic [SETTLE_W-1:0] settle,
			input logic [HOLD_W-1:0] hold, input logic [INDEX_W-1:0] total);
		write_register(mpsas_pkg::REG_SETTLE_TIME, {15'($urandom()), settle});
		write_register(mpsas_pkg::REG_HOLD_ANGLE, hold);
		write_register(mpsas_pkg::REG_POINT_TOTAL, {39'({$urandom(), $urandom()}), total});
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (tick_backlog.size() != 0 || tick_bus.valid
			|| pending_point_results.size() != 0);
	endtask

	// tick driver
	always @(posedge clk) begin : tick_driver
		tick_item_t seen;
		tick_item_t nxt;
		if (arst_n) begin
			if (tick_bus.valid && tick_bus.ready) begin
				seen.tick_us = tick_bus.tick_us;
				seen.speed = tick_bus.speed;
				seen.load_torque = tick_bus.load_torque;
				pending_point_results.push_back(settle_average_tick(seen));
			end
			if (!tick_bus.valid || tick_bus.ready) begin
				if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = tick_backlog.pop_front();
					tick_bus.valid <= 1'b1;
					tick_bus.tick_us <= nxt.tick_us;
					tick_bus.speed <= nxt.speed;
					tick_bus.load_torque <= nxt.load_torque;
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		point_result_t got;
		point_result_t want;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				got.point_complete = result_bus.point_complete;
				got.all_done = result_bus.all_done;
				got.mean_speed = result_bus.mean_speed;
				got.mean_torque = result_bus.mean_torque;
				got.point_index = result_bus.point_index;
				if (pending_point_results.size() == 0) begin
					note_failure("result transaction with no tick outstanding");
				end else begin
					want = pending_point_results.pop_front();
					if (got.point_complete !== want.point_complete)
						note_failure($sformatf("result %0d point_complete %b, expected %b",
							results_seen, got.point_complete, want.point_complete));
					if (got.all_done !== want.all_done)
						note_failure($sformatf("result %0d all_done %b, expected %b",
							results_seen, got.all_done, want.all_done));
					if (got.mean_speed !== want.mean_speed)
						note_failure($sformatf("result %0d mean_speed %0d, expected %0d",
							results_seen, got.mean_speed, want.mean_speed));
					if (got.mean_torque !== want.mean_torque)
						note_failure($sformatf("result %0d mean_torque %0d, expected %0d",
							results_seen, got.mean_torque, want.mean_torque));
					if (got.point_index !== want.point_index)
						note_failure($sformatf("result %0d point_index %0d, expected %0d",
							results_seen, got.point_index, want.point_index));
				end
				results_seen++;
			end
			result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: work outstanding but no transaction for too long
	always @(posedge clk) begin
		if (arst_n && (tick_backlog.size() != 0 || tick_bus.valid
				|| pending_point_results.size() != 0)
				&& !(tick_bus.valid && tick_bus.ready)
				&& !(result_bus.valid && result_bus.ready)) begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	initial begin : stimulus
		int phase;
		int count;
		int half;
		int total_pick;
		logic [SETTLE_W-1:0] settle_pick;
		logic [HOLD_W-1:0]   hold_pick;

		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.tick_us = '0;
		tick_bus.speed = '0;
		tick_bus.load_torque = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		set_traffic(0);

		// reset registers: settle crossed on the seventh full tick, hold on the ninth
		queue_tick('0, '0, '0);
		repeat (7) queue_tick('1, SPEED_LOW, TORQUE_LOW);
		repeat (2) queue_tick('1, SPEED_HIGH, TORQUE_HIGH);
		wait_idle();

		// elapsed equal to settle does not sample, hold met exactly, negative means
		write_register(REG_SPARE, CFG_DATA_W'({$urandom(), $urandom()}));
		apply_settings(32'd100, 47'd1000, 8'd3);
		queue_tick(16'd100, 19'sd7, 16'sd1);
		queue_tick(16'd1, 19'sd5, 16'sd3);
		queue_tick(16'd1, 19'sd995, 16'sd4);
		queue_tick(16'd101, -19'sd3, -16'sd7);
		queue_tick(16'd101, -19'sd4, -16'sd2);
		queue_tick(16'd1, -19'sd293, -16'sd1);
		queue_tick(16'd200, -19'sd5, 16'sd9);
		queue_tick('1, SPEED_HIGH, TORQUE_HIGH);
		wait_idle();

		// empty sequence
		write_register(mpsas_pkg::REG_POINT_TOTAL, '0);
		queue_tick(16'd1, 19'sd1, 16'sd1);
		wait_idle();

		// zero hold: a point with no samples, then one with a single sample
		apply_settings(32'd100, '0, 8'd5);
		queue_tick(16'd0, 19'sd123, 16'sd45);
		queue_tick(16'd150, -19'sd77, -16'sd9);
		wait_idle();

		// total lowered below the current point
		write_register(mpsas_pkg::REG_POINT_TOTAL, 47'd2);
		queue_tick(16'd1, 19'sd1, 16'sd1);
		wait_idle();

		for (phase = 0; phase < 8; phase++) begin
			set_traffic(phase % 4);
			settle_pick = (phase == 0) ? '0 : SETTLE_W'($urandom_range(3000));
			case (phase)
				1: hold_pick = HOLD_W'($urandom_range(1000, 1));
				3: hold_pick = '1;
				7: hold_pick = '0;
				default: hold_pick = HOLD_W'($urandom_range(2000000000, 1000000));
			endcase
			total_pick = int'(point_number_now) + 18 + int'($urandom_range(12));
			if (phase == 7 || total_pick > 255) begin
				total_pick = 255;
			end
			count = (phase == 7) ? 260 : 160;
			apply_settings(settle_pick, hold_pick, INDEX_W'(total_pick));
			half = count / 2;
			repeat (half) tick_backlog.push_back(random_tick());
			// hold the sender off until every result of the first half is back
			wait_idle();
			repeat (count - half) tick_backlog.push_back(random_tick());
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (pending_point_results.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_point_results.size()));
		end
		if (failure_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mpsas_pkg.sv
hdl/mpsas_if.sv
hdl/mpsas_front.sv
hdl/mpsas_fifo.sv
hdl/mpsas_div.sv
hdl/mpsas_back.sv
hdl/multi_point_settle_average_sequencer_core.sv
dv/tb_multi_point_settle_average_sequencer_core.sv
